>>> hw/rtl/fwdp_pkg.sv
// fwdp_pkg: request and status codes, payload structs and the default depth
// for the queue with duplicate purge. No dependencies.
package fwdp_pkg;

   // default number of words held
   localparam int DEPTH_DEFAULT = 16;

   // request codes
   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_PURGE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // saturation value of the removal count
   localparam logic [3:0] REMOVED_MAX = 4'hF;

   // input transfer
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] value;
   } fwdp_req_type;

   // result transfer
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped_value;
      logic [3:0]         removed_count;
      logic signed [31:0] front_value;
      logic [4:0]         occupancy;
      logic               is_empty;
   } fwdp_rsp_type;

endpackage

>>> hw/rtl/fifo_with_duplicate_purge_core.sv
// fifo_with_duplicate_purge_core: bounded ring queue of signed words with push,
// pop and an in-place duplicate purge run by a small sequencer.
// Depends on fwdp_pkg.

// Every request ends with a read of the front word through S_FRONT_RD and
// S_FRONT_WAIT before the result is registered; a pop of a held word first passes
// S_POP_WAIT, and a purge walks the held words through the single read port of the
// ring store, one word a cycle, while a shared comparator decides per word whether
// it is kept and moved down.
// One request is worked at a time; a new request is taken once the previous
// result has left the output register. The store holds no reset value; only
// held positions are ever used.
module fifo_with_duplicate_purge_core
   import fwdp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fwdp_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fwdp_rsp_type rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_POP_WAIT   = 3'd1;
   localparam logic [2:0] S_PURGE      = 3'd2;
   localparam logic [2:0] S_FRONT_RD   = 3'd3;
   localparam logic [2:0] S_FRONT_WAIT = 3'd4;

   // ring position of base plus offset
   function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic [CW-1:0]      wr_ff, wr_in;
   logic               pend_ff, pend_in;
   logic               seen_ff, seen_in;
   logic [3:0]         removed_ff, removed_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] popped_ff, popped_in;
   logic signed [31:0] word_ff, word_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fwdp_rsp_type       rsp_ff, rsp_in;

   logic signed [31:0] store_ff [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic signed [31:0] mem_wd;
   logic [AW-1:0]      mem_ra;
   logic               accept;
   logic               full;
   logic               match;
   logic [CW+4:0]      occ_ext;

   assign req_stall   = !((state_ff == S_IDLE) && !rsp_valid_ff);
   assign accept      = req_valid && !req_stall;
   assign full        = (count_ff == CW'(DEPTH));
   assign match       = (rd_data_ff == word_ff);
   assign occ_ext     = {5'd0, count_ff};
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // single read port: purge walk address, else the front
   assign mem_ra = (state_ff == S_PURGE) ? ring_slot(head_ff, issue_ff) : head_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      wr_in        = wr_ff;
      pend_in      = pend_ff;
      seen_in      = seen_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = ring_slot(head_ff, count_ff);
      mem_wd       = req_payload.value;

      // result leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in  = ST_OK;
               popped_in  = '0;
               removed_in = '0;
               word_in    = req_payload.value;
               state_in   = S_FRONT_RD;
               unique case (req_payload.req_type)
                  REQ_PUSH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_POP: begin
                     // front read is already under way at head
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_POP_WAIT;
                     end
                  end
                  REQ_PURGE: begin
                     issue_in = '0;
                     wr_in    = '0;
                     pend_in  = 1'b0;
                     seen_in  = 1'b0;
                     state_in = S_PURGE;
                  end
                  default: begin
                     state_in = S_FRONT_RD;
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            popped_in = rd_data_ff;
            head_in   = ring_slot(head_ff, CW'(1));
            count_in  = count_ff - 1'b1;
            state_in  = S_FRONT_RD;
         end
         S_PURGE: begin
            // issue the next read of the walk
            if (issue_ff < count_ff) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // compare the word read last cycle, keep or drop it
            if (pend_ff) begin
               if (match && seen_ff) begin
                  if (removed_ff != REMOVED_MAX) begin
                     removed_in = removed_ff + 1'b1;
                  end
               end else begin
                  mem_we = 1'b1;
                  mem_wa = ring_slot(head_ff, wr_ff);
                  mem_wd = rd_data_ff;
                  wr_in  = wr_ff + 1'b1;
                  if (match) begin
                     seen_in = 1'b1;
                  end
               end
            end
            // walk done
            if (!(issue_ff < count_ff) && !pend_ff) begin
               count_in = wr_ff;
               state_in = S_FRONT_RD;
            end
         end
         S_FRONT_RD: begin
            state_in = S_FRONT_WAIT;
         end
         S_FRONT_WAIT: begin
            rsp_in.status        = status_ff;
            rsp_in.popped_value  = popped_ff;
            rsp_in.removed_count = removed_ff;
            rsp_in.front_value   = (count_ff != '0) ? rd_data_ff : 32'sd0;
            rsp_in.occupancy     = occ_ext[4:0];
            rsp_in.is_empty      = (count_ff == '0);
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and payload registers
   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      wr_ff      <= wr_in;
      seen_ff    <= seen_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      popped_ff  <= popped_in;
      word_ff    <= word_in;
      rsp_ff     <= rsp_in;
   end

   // ring store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store_ff[mem_ra];
   end

endmodule

>>> verif/fwdp_queue_checker.sv
`timescale 1ns / 1ps
// fwdp_queue_checker: watches the request and result channels of the purge queue,
// keeps its own copy of the ring and compares every result transfer field by field.
// Depends on fwdp_pkg.
module fwdp_queue_checker
   import fwdp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  fwdp_req_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  fwdp_rsp_type rsp_payload,
   output int           error_count,
   output int           results_due
);

   // shadow copy of the queue
   logic signed [31:0] ring [DEPTH];
   int unsigned        head_pos;
   int unsigned        word_count;
   int                 mismatches;
   fwdp_rsp_type       results_owed [$];

   function automatic int unsigned ring_slot(input int unsigned offset);
      return (head_pos + offset) % DEPTH;
   endfunction

   // apply one request to the shadow queue and build the result it causes
   function automatic fwdp_rsp_type queue_result(input fwdp_req_type req);
      fwdp_rsp_type       res;
      int unsigned        rd;
      int unsigned        kept;
      int unsigned        dropped;
      bit                 seen;
      logic signed [31:0] word;
      res = '0;
      res.status = ST_OK;
      kept = 0;
      dropped = 0;
      seen = 1'b0;
      case (req.req_type)
         REQ_PUSH: begin
            if (word_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               ring[ring_slot(word_count)] = req.value;
               word_count++;
            end
         end
         REQ_POP: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.popped_value = ring[ring_slot(0)];
               head_pos = ring_slot(1);
               word_count--;
            end
         end
         REQ_PURGE: begin
            // keep the first match, squeeze out later ones in order
            for (rd = 0; rd < word_count; rd++) begin
               word = ring[ring_slot(rd)];
               if (word == req.value && seen) begin
                  dropped++;
               end else begin
                  if (word == req.value) seen = 1'b1;
                  ring[ring_slot(kept)] = word;
                  kept++;
               end
            end
            word_count = kept;
            res.removed_count = (dropped > 32'(REMOVED_MAX)) ? REMOVED_MAX : dropped[3:0];
         end
         default: ;
      endcase
      if (word_count != 0) res.front_value = ring[ring_slot(0)];
      res.occupancy = word_count[4:0];
      res.is_empty  = (word_count == 0);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 'h%08h actual 'h%08h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      fwdp_rsp_type want;
      if (reset) begin
         head_pos = 0;
         word_count = 0;
         mismatches = 0;
         results_owed.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (results_owed.size() == 0) begin
               $display("%0t: result transfer with none expected, actual %p", $time,
                        rsp_payload);
               mismatches++;
            end else begin
               want = results_owed.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_payload.status));
               check_field("popped_value", want.popped_value, rsp_payload.popped_value);
               check_field("removed_count", 32'(want.removed_count),
                           32'(rsp_payload.removed_count));
               check_field("front_value", want.front_value, rsp_payload.front_value);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_payload.occupancy));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_payload.is_empty));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            results_owed.push_back(queue_result(req_payload));
      end
      results_due <= results_owed.size();
      error_count <= mismatches;
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: drives requests and result stalls into the purge queue and gives
// the verdict. Depends on fwdp_pkg, fwdp_queue_checker and the core.
module testbench;
   import fwdp_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         QUIET_LIMIT  = 5000;
   localparam int         RANDOM_ITEMS = 1300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   fwdp_req_type       req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   fwdp_rsp_type       rsp_payload;
   int                 error_count;
   int                 results_due;
   int                 send_gap_pct = 30;
   int                 stall_pct = 65;
   int                 quiet_cycles = 0;
   logic signed [31:0] value_pool [4];

   fifo_with_duplicate_purge_core u_dut (.*);
   fwdp_queue_checker u_checker (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request transfer, with random gaps in front of it
   task automatic send_request(input logic [1:0] kind, input logic signed [31:0] word);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{req_type: kind, value: word};
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // mostly pool words so purges find duplicates, sometimes any word
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(3)];
      return $urandom;
   endfunction

   task automatic run_random(input int count);
      int n;
      int push_pct;
      int roll;
      push_pct = 50;
      foreach (value_pool[i]) value_pool[i] = $urandom;
      for (n = 0; n < count; n++) begin
         // drift between filling and draining so full and empty both show up
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 25;
               1: push_pct = 50;
               default: push_pct = 80;
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 3)
            send_request(REQ_UNUSED, $urandom);
         else if (roll < 18)
            send_request(REQ_PURGE, pick_value());
         else if ($urandom_range(99) < push_pct)
            send_request(REQ_PUSH, pick_value());
         else
            send_request(REQ_POP, $urandom);
      end
   endtask

   initial begin
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty queue corner cases
      send_request(REQ_POP, 32'sd0);
      send_request(REQ_PURGE, 32'sd7);
      send_request(REQ_UNUSED, -32'sd1);
      // fill with one word, push on full, then purge down to a single copy
      for (k = 0; k < 16; k++) send_request(REQ_PUSH, 32'sh80000000);
      send_request(REQ_PUSH, 32'sh7FFFFFFF);
      send_request(REQ_PURGE, 32'sh80000000);
      send_request(REQ_POP, 32'sd0);
      // extremes, a single duplicate, an absent word
      send_request(REQ_PUSH, 32'sh7FFFFFFF);
      send_request(REQ_PUSH, 32'sd0);
      send_request(REQ_PUSH, -32'sd1);
      send_request(REQ_PUSH, 32'sh7FFFFFFF);
      send_request(REQ_PURGE, 32'sh7FFFFFFF);
      send_request(REQ_PURGE, 32'sh12345678);
      send_request(REQ_UNUSED, 32'sh55AA55AA);
      send_request(REQ_POP, -32'sd1);
      wait_drained();

      // three idling profiles, queue drained between them
      run_random(RANDOM_ITEMS / 3);
      wait_drained();
      send_gap_pct = 65;
      stall_pct <= 30;
      run_random(RANDOM_ITEMS / 3);
      wait_drained();
      send_gap_pct = 0;
      stall_pct <= 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      wait_drained();
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
